// File: design/tdpu_pkg.sv
// Shared types and constants for the Thumb data-processing unit.
// Used by the decode front, the request queue and the execute back end.
package tdpu_pkg;

   localparam int QUEUE_DEPTH = 2;

   // Operation codes of the execute unit
   typedef enum logic [4:0] {
      OP_AND, OP_EOR, OP_LSL, OP_LSR, OP_ASR, OP_ADC, OP_SBC, OP_ROR,
      OP_TST, OP_NEG, OP_CMP, OP_CMN, OP_ORR, OP_MUL, OP_BIC, OP_MVN,
      OP_ADD, OP_SUB, OP_MOV
   } op_type;

   // Decoded request handed from the front to the back end
   typedef struct packed {
      logic       valid_fmt;   // one of formats 1 to 4
      op_type     op;
      logic       we;
      logic [2:0] rd;
      logic [2:0] ra;          // first operand register
      logic [2:0] rb;          // second operand register
      logic       b_imm;       // second operand is the immediate
      logic [7:0] imm;
   } dec_type;

endpackage

// File: design/tdpu_front.sv
// Decode front: classifies a Thumb halfword into a decoded request.
// Depends on tdpu_pkg.
module tdpu_front (
   input  logic [15:0]       instruction,
   output tdpu_pkg::dec_type dec
);

   // Decode formats 1 to 4
   always_comb begin
      dec           = '0;
      dec.op        = tdpu_pkg::OP_MOV;
      if (instruction[15:11] == 5'b00011) begin
         dec.valid_fmt = 1'b1;
         dec.we        = 1'b1;
         dec.rd        = instruction[2:0];
         dec.ra        = instruction[5:3];
         dec.rb        = instruction[8:6];
         dec.b_imm     = instruction[10];
         dec.imm       = {5'd0, instruction[8:6]};
         dec.op        = instruction[9] ? tdpu_pkg::OP_SUB : tdpu_pkg::OP_ADD;
      end else if (instruction[15:13] == 3'b000) begin
         dec.valid_fmt = 1'b1;
         dec.we        = 1'b1;
         dec.rd        = instruction[2:0];
         dec.ra        = instruction[5:3];
         dec.b_imm     = 1'b1;
         dec.imm       = {3'd0, instruction[10:6]};
         // non-LSL by zero means by 32
         if (instruction[12:11] != 2'b00 && instruction[10:6] == 5'd0) begin
            dec.imm = 8'd32;
         end
         case (instruction[12:11])
            2'b00:   dec.op = tdpu_pkg::OP_LSL;
            2'b01:   dec.op = tdpu_pkg::OP_LSR;
            default: dec.op = tdpu_pkg::OP_ASR;
         endcase
      end else if (instruction[15:13] == 3'b001) begin
         dec.valid_fmt = 1'b1;
         dec.we        = 1'b1;
         dec.rd        = instruction[10:8];
         dec.ra        = instruction[10:8];
         dec.b_imm     = 1'b1;
         dec.imm       = instruction[7:0];
         case (instruction[12:11])
            2'b00:   dec.op = tdpu_pkg::OP_MOV;
            2'b01: begin
               dec.op = tdpu_pkg::OP_CMP;
               dec.we = 1'b0;
            end
            2'b10:   dec.op = tdpu_pkg::OP_ADD;
            default: dec.op = tdpu_pkg::OP_SUB;
         endcase
      end else if (instruction[15:10] == 6'b010000) begin
         dec.valid_fmt = 1'b1;
         dec.rd        = instruction[2:0];
         dec.ra        = instruction[2:0];
         dec.rb        = instruction[5:3];
         dec.op        = tdpu_pkg::op_type'({1'b0, instruction[9:6]});
         dec.we        = !(instruction[9:6] inside {4'h8, 4'hA, 4'hB});
      end
   end

endmodule

// File: design/tdpu_queue.sv
// Short request queue between the decode front and the execute back end.
// Depends on tdpu_pkg.
module tdpu_queue #(
   parameter int Depth = tdpu_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdpu_pkg::dec_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tdpu_pkg::dec_type pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tdpu_pkg::dec_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/tdpu_back.sv
// Execute back end: register file, flags, ALU, shifter, multiplier and
// the output register.  Depends on tdpu_pkg.
module tdpu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tdpu_pkg::dec_type q_data,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);

   logic [31:0] regs_ff [8];
   logic [3:0]  flags_ff;            // N Z C V
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff;

   logic [31:0] a, b, res;
   logic [32:0] sum;
   logic [32:0] wide;
   logic [7:0]  n;
   logic        fc, fv, cin, is_add;
   logic [31:0] addb;
   logic [4:0]  m;
   logic        fn_new, fz_new;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   // Operand selection
   always_comb begin
      a = regs_ff[q_data.ra];
      b = q_data.b_imm ? {24'd0, q_data.imm} : regs_ff[q_data.rb];
      if (q_data.op == tdpu_pkg::OP_NEG) begin
         a = '0;
      end
   end

   // Adder, shifter, multiplier and logic
   always_comb begin
      fc     = flags_ff[1];
      fv     = flags_ff[0];
      res    = '0;
      n      = b[7:0];
      m      = n[4:0];
      wide   = '0;
      is_add = 1'b0;
      cin    = 1'b0;
      addb   = b;
      case (q_data.op)
         tdpu_pkg::OP_ADD, tdpu_pkg::OP_CMN: is_add = 1'b1;
         tdpu_pkg::OP_SUB, tdpu_pkg::OP_CMP, tdpu_pkg::OP_NEG: begin
            is_add = 1'b1;
            addb   = ~b;
            cin    = 1'b1;
         end
         tdpu_pkg::OP_ADC: begin
            is_add = 1'b1;
            cin    = flags_ff[1];
         end
         tdpu_pkg::OP_SBC: begin
            is_add = 1'b1;
            addb   = ~b;
            cin    = flags_ff[1];
         end
         default: is_add = 1'b0;
      endcase
      sum = {1'b0, a} + {1'b0, addb} + {32'd0, cin};
      if (is_add) begin
         res = sum[31:0];
         fc  = sum[32];
         fv  = (~(a[31] ^ addb[31])) & (a[31] ^ sum[31]);
      end else begin
         case (q_data.op)
            tdpu_pkg::OP_AND, tdpu_pkg::OP_TST: res = a & b;
            tdpu_pkg::OP_EOR: res = a ^ b;
            tdpu_pkg::OP_ORR: res = a | b;
            tdpu_pkg::OP_BIC: res = a & ~b;
            tdpu_pkg::OP_MVN: res = ~b;
            tdpu_pkg::OP_MOV: res = b;
            tdpu_pkg::OP_MUL: res = a * b;
            tdpu_pkg::OP_LSL: begin
               res = a;
               if (n != 8'd0) begin
                  wide = (n > 8'd32) ? 33'd0 : ({1'b0, a} << n[5:0]);
                  res  = wide[31:0];
                  fc   = wide[32];
               end
            end
            tdpu_pkg::OP_LSR: begin
               res = a;
               if (n != 8'd0) begin
                  wide = (n > 8'd32) ? 33'd0 : ({a, 1'b0} >> n[5:0]);
                  res  = wide[32:1];
                  fc   = wide[0];
               end
            end
            tdpu_pkg::OP_ASR: begin
               res = a;
               if (n != 8'd0) begin
                  wide = $signed({a, 1'b0}) >>> ((n > 8'd32) ? 6'd32 : n[5:0]);
                  res  = wide[32:1];
                  fc   = wide[0];
               end
            end
            tdpu_pkg::OP_ROR: begin
               res = a;
               if (n != 8'd0) begin
                  if (m != 5'd0) begin
                     res = (a >> m) | (a << (6'd32 - {1'b0, m}));
                  end
                  fc = res[31];
               end
            end
            default: res = '0;
         endcase
      end
      fn_new = res[31];
      fz_new = (res == 32'd0);
   end

   // Hold the output register while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop && q_data.valid_fmt) begin
            flags_ff <= {fn_new, fz_new, fc, fv};
            if (q_data.we) begin
               regs_ff[q_data.rd] <= res;
            end
         end
      end
   end

   // Load the result; unknown formats report the held flags
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_data.valid_fmt) begin
            out_data_ff <= {fv, fc, fz_new, fn_new, res, q_data.rd, q_data.we};
         end else begin
            out_data_ff <= {flags_ff[0], flags_ff[1], flags_ff[2], flags_ff[3],
                            32'd0, 3'd0, 1'b0};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_data_ff))
      else $error("result dropped while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[0] |-> out_data_ff[37] == (out_data_ff[35:4] == 32'd0))
      else $error("Z flag disagrees with written value");
   a_neg: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[0] |-> out_data_ff[36] == out_data_ff[35])
      else $error("N flag disagrees with written value");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule

// File: design/thumb_data_processing_unit.sv
// Top level of the Thumb data-processing unit.
// Instantiates tdpu_front, tdpu_queue and tdpu_back; depends on tdpu_pkg.
//
// Usage:
//   Request channel req_*: one 16-bit Thumb halfword per request.
//   Result channel rsp_*: exactly one result per request, in order.
//   A request is taken when req_tvalid and req_tready are both high.
//   When the queue and the output register are empty, a request passes
//   through the queue slot and then the output register before rsp_tvalid
//   rises; throughput is one request per cycle while the receiver does not
//   stall, through the execute stage (register file read, ALU or 32x32
//   multiply, write back).
//   The front decodes into a small queue; the back end pops one entry a
//   cycle whenever its output register is empty or being emptied.
//   When the receiver stalls, the result is held, the queue fills and
//   req_tready drops once it is full.
//   Reset clears all eight low registers, the NZCV flags and the queue.
module thumb_data_processing_unit #(
   parameter int QueueDepth = tdpu_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // instruction[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // write_enable[0], dest_index[3:1],
                                    // result_value[35:4], flag_n[36],
                                    // flag_z[37], flag_c[38], flag_v[39]
);

   tdpu_pkg::dec_type dec, q_data;
   logic q_full, q_valid, q_pop;

   tdpu_front u_front (
      .instruction (req_tdata),
      .dec         (dec)
   );

   tdpu_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_data (dec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   tdpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = !q_full;

endmodule
